FILE: src/fdrp_pkg.sv
// shared types, constants and helper functions for the four-d rotate and project engine
package fdrp_pkg;

   localparam int VERTEX_COUNT_DEF = 16;
   localparam int EMIT_MAX         = 16;
   localparam int CORDIC_STEPS     = 16;
   localparam int DIV_W            = 30;
   localparam int FULL_TURN        = 36000;
   localparam int HALF_TURN        = 18000;
   localparam int QUARTER_TURN     = 9000;
   localparam int CORDIC_X0        = 9949;
   localparam int ONE_Q13          = 8192;
   localparam int ONE_Q14          = 16384;
   localparam logic [14:0] EYE_RESET = 15'd16384;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_ROTATE  = 2'd1,
      OP_PROJECT = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      REG_WORLD_X = 2'd0,
      REG_WORLD_Y = 2'd1,
      REG_WORLD_Z = 2'd2,
      REG_EYE     = 2'd3
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_CORDIC,
      ST_READ,
      ST_LATCH,
      ST_MUL,
      ST_WRITE,
      ST_DIV_SETUP,
      ST_DIV,
      ST_DIV_FIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic signed [15:0] w;
      logic signed [15:0] r;
      logic signed [15:0] g;
      logic signed [15:0] b;
   } vertex_type;

   function automatic logic signed [24:0] atan_entry(input logic [3:0] i);
      logic signed [24:0] v;
      case (i)
         4'd0:    v = 25'sd1152000;
         4'd1:    v = 25'sd680065;
         4'd2:    v = 25'sd359328;
         4'd3:    v = 25'sd182400;
         4'd4:    v = 25'sd91554;
         4'd5:    v = 25'sd45822;
         4'd6:    v = 25'sd22916;
         4'd7:    v = 25'sd11459;
         4'd8:    v = 25'sd5730;
         4'd9:    v = 25'sd2865;
         4'd10:   v = 25'sd1432;
         4'd11:   v = 25'sd716;
         4'd12:   v = 25'sd358;
         4'd13:   v = 25'sd179;
         4'd14:   v = 25'sd90;
         4'd15:   v = 25'sd45;
         default: v = 25'sd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
      logic signed [15:0] r;
      if (v > 20'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -20'sd32768) begin
         r = -16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   function automatic vertex_type reset_vertex(input logic [6:0] idx);
      vertex_type v;
      v.x = idx[0] ? 16'sd8192 : -16'sd8192;
      v.y = idx[1] ? 16'sd8192 : -16'sd8192;
      v.z = idx[2] ? 16'sd8192 : -16'sd8192;
      v.w = (idx < 7'd8) ? 16'sd0 : -16'sd8192;
      v.r = 16'(ONE_Q13);
      v.g = 16'(ONE_Q13);
      v.b = 16'(ONE_Q13);
      return v;
   endfunction

endpackage

FILE: src/four_d_rotate_project_engine.sv
// four-d vertex store with plane rotation and perspective projection
//
// A request beat on req_* carries one command. Load writes one vertex.
// Rotate reduces the angle, runs a 16-step cordic for sine and cosine,
// then walks every stored vertex through one shared 16x16 multiplier
// with accumulator. Project walks the first (at most 16) vertices; each
// needs three 30-step restoring divisions on one shared divider, skipped
// when behind the eye, and each result leaves as one rsp beat with
// rsp_last on the final vertex.
// req_stall is high for the whole run of a command. A stalled rsp beat
// holds its payload and the sequencer waits for it.
// Reset restores the cube vertices with white colours through per-entry
// valid bits, clears the world offsets and sets the eye distance to 2.0.
// csr writes are always taken and must be issued while the block is idle.
module four_d_rotate_project_engine #(
   parameter int VERTEX_COUNT = fdrp_pkg::VERTEX_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  fdrp_pkg::op_type    req_op,
   input  logic [2:0]          req_plane,
   input  logic signed [16:0]  req_angle,
   input  logic [3:0]          req_vertex_index,
   input  logic signed [15:0]  req_pos_x,
   input  logic signed [15:0]  req_pos_y,
   input  logic signed [15:0]  req_pos_z,
   input  logic signed [15:0]  req_pos_w,
   input  logic signed [15:0]  req_in_red,
   input  logic signed [15:0]  req_in_green,
   input  logic signed [15:0]  req_in_blue,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [3:0]          rsp_out_index,
   output logic signed [31:0]  rsp_proj_x,
   output logic signed [31:0]  rsp_proj_y,
   output logic signed [31:0]  rsp_proj_z,
   output logic signed [15:0]  rsp_out_red,
   output logic signed [15:0]  rsp_out_green,
   output logic signed [15:0]  rsp_out_blue,
   output logic                rsp_behind_eye,
   output logic                rsp_last,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  fdrp_pkg::reg_index_type csr_index,
   input  logic [31:0]         csr_data
);
   import fdrp_pkg::*;

   localparam int AW     = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
   localparam int CW     = AW + 1;
   localparam int EMIT_N = (VERTEX_COUNT < EMIT_MAX) ? VERTEX_COUNT : EMIT_MAX;
   localparam logic [CW-1:0] VC_LAST   = CW'(VERTEX_COUNT - 1);
   localparam logic [CW-1:0] EMIT_LAST = CW'(EMIT_N - 1);

   state_type state_ff, state_in;

   logic signed [31:0] world_x_ff, world_y_ff, world_z_ff;
   logic [14:0]        eye_ff;

   vertex_type         mem [VERTEX_COUNT];
   logic [VERTEX_COUNT-1:0] valid_ff;
   vertex_type         rd_ff;
   logic               rvalid_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_wa;
   vertex_type         mem_wd;

   op_type             op_ff;
   logic [2:0]         plane_ff;
   logic signed [17:0] ang_ff;
   logic signed [19:0] cx_ff, cy_ff;
   logic signed [24:0] cz_ff;
   logic               flip_ff;
   logic signed [15:0] sin_ff, cos_ff;
   logic [3:0]         step_ff;
   logic [CW-1:0]      vi_ff;
   vertex_type         vtx_ff;
   logic signed [32:0] acc_ff;
   logic signed [15:0] tmp_ff;

   logic [16:0]        den_ff;
   logic               behind_ff;
   logic [1:0]         comp_ff;
   logic [DIV_W-1:0]   dvd_ff;
   logic [15:0]        rem_ff;
   logic [4:0]         dcnt_ff;
   logic               neg_ff;
   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic               rsp_valid_ff;

   logic               req_take;
   logic [6:0]         load_idx;
   logic               load_ok;

   // angle reduction
   logic signed [17:0] r_wrap, r_fold;
   logic               r_flip;

   // cordic step
   logic signed [19:0] cdx, cdy, cx_nx, cy_nx;
   logic signed [24:0] cz_nx;

   // rotate datapath
   logic signed [15:0] axa, axb, opa, opb, opnd, coef;
   logic signed [31:0] prod;
   logic signed [32:0] sum;
   logic signed [33:0] rnd_wide;
   logic signed [15:0] rnd;

   // project datapath
   logic signed [17:0] den_calc;
   logic               behind_now;
   logic signed [15:0] pcoord;
   logic [16:0]        pabs;
   logic [16:0]        rem_sh;
   logic               rem_ge;
   logic signed [31:0] pworld;
   logic signed [32:0] qs, psum;
   logic signed [31:0] pres;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign load_idx  = 7'(req_vertex_index);
   assign load_ok   = (load_idx < 7'(VERTEX_COUNT));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_op)
                  OP_ROTATE:  state_in = (req_plane <= 3'd5) ? ST_REDUCE : ST_IDLE;
                  OP_PROJECT: state_in = ST_READ;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_REDUCE: begin
            if (!ang_ff[17] && ang_ff < 18'sd36000) begin
               state_in = ST_CORDIC;
            end
         end
         ST_CORDIC:    state_in = (step_ff == 4'd15) ? ST_READ : ST_CORDIC;
         ST_READ:      state_in = ST_LATCH;
         ST_LATCH:     state_in = (op_ff == OP_ROTATE) ? ST_MUL : ST_DIV_SETUP;
         ST_MUL:       state_in = (step_ff == 4'd7) ? ST_WRITE : ST_MUL;
         ST_WRITE:     state_in = (vi_ff == VC_LAST) ? ST_IDLE : ST_READ;
         ST_DIV_SETUP: state_in = behind_now ? ST_DIV_FIN : ST_DIV;
         ST_DIV:       state_in = (dcnt_ff == 5'(DIV_W - 1)) ? ST_DIV_FIN : ST_DIV;
         ST_DIV_FIN:   state_in = (comp_ff == 2'd2) ? ST_EMIT : ST_DIV_SETUP;
         ST_EMIT: begin
            if (!rsp_stall) begin
               state_in = (vi_ff == EMIT_LAST) ? ST_IDLE : ST_READ;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // memory write port selection
   always_comb begin
      mem_we = 1'b0;
      mem_wa = vi_ff[AW-1:0];
      mem_wd = vtx_ff;
      if (state_ff == ST_IDLE && req_take && req_op == OP_LOAD && load_ok) begin
         mem_we = 1'b1;
         mem_wa = load_idx[AW-1:0];
         mem_wd = '{req_pos_x, req_pos_y, req_pos_z, req_pos_w,
                    req_in_red, req_in_green, req_in_blue};
      end else if (state_ff == ST_WRITE) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_ff     <= mem[vi_ff[AW-1:0]];
      rvalid_ff <= valid_ff[vi_ff[AW-1:0]];
   end

   // angle reduction and fold
   always_comb begin
      r_wrap = (ang_ff > 18'sd18000) ? ang_ff - 18'sd36000 : ang_ff;
      r_flip = 1'b0;
      r_fold = r_wrap;
      if (r_wrap > 18'sd9000) begin
         r_fold = 18'sd18000 - r_wrap;
         r_flip = 1'b1;
      end else if (r_wrap < -18'sd9000) begin
         r_fold = -18'sd18000 - r_wrap;
         r_flip = 1'b1;
      end
   end

   assign cdx = cy_ff >>> step_ff;
   assign cdy = cx_ff >>> step_ff;

   always_comb begin
      if (!cz_ff[24]) begin
         cx_nx = cx_ff - cdx;
         cy_nx = cy_ff + cdy;
         cz_nx = cz_ff - atan_entry(step_ff);
      end else begin
         cx_nx = cx_ff + cdx;
         cy_nx = cy_ff - cdy;
         cz_nx = cz_ff + atan_entry(step_ff);
      end
   end

   // rotation operand selection, file plane labels
   always_comb begin
      case (plane_ff)
         3'd0:    begin axa = vtx_ff.y; axb = vtx_ff.z; end
         3'd1:    begin axa = vtx_ff.x; axb = vtx_ff.z; end
         3'd2:    begin axa = vtx_ff.x; axb = vtx_ff.y; end
         3'd3:    begin axa = vtx_ff.z; axb = vtx_ff.w; end
         3'd4:    begin axa = vtx_ff.x; axb = vtx_ff.w; end
         default: begin axa = vtx_ff.y; axb = vtx_ff.w; end
      endcase
      opa  = step_ff[2] ? vtx_ff.r : axa;
      opb  = step_ff[2] ? vtx_ff.g : axb;
      opnd = step_ff[0] ? opb : opa;
      coef = (step_ff[0] ^ step_ff[1]) ? sin_ff : cos_ff;
      prod = opnd * coef;
      if (!step_ff[0]) begin
         sum = 33'(prod);
      end else if (step_ff[1]) begin
         sum = acc_ff + 33'(prod);
      end else begin
         sum = acc_ff - 33'(prod);
      end
      rnd_wide = (34'(sum) + 34'sd8192) >>> 14;
      rnd      = sat16(rnd_wide[19:0]);
   end

   // projection datapath
   always_comb begin
      den_calc = $signed({3'b000, eye_ff}) - 18'(vtx_ff.w);
      case (comp_ff)
         2'd0:    begin pcoord = vtx_ff.x; pworld = world_x_ff; end
         2'd1:    begin pcoord = vtx_ff.y; pworld = world_y_ff; end
         default: begin pcoord = vtx_ff.z; pworld = world_z_ff; end
      endcase
      pabs   = pcoord[15] ? 17'(-17'(pcoord)) : 17'(pcoord);
      rem_sh = {rem_ff, dvd_ff[DIV_W-1]};
      rem_ge = (rem_sh >= den_ff);
      qs     = neg_ff ? -33'($signed({3'b000, dvd_ff})) : $signed({3'b000, dvd_ff});
      psum   = qs + 33'(pworld);
      if (behind_ff) begin
         if (pcoord > 16'sd0) begin
            pres = 32'sh7fffffff;
         end else if (pcoord < 16'sd0) begin
            pres = 32'sh80000000;
         end else begin
            pres = pworld;
         end
      end else if (psum > 33'sh07fffffff) begin
         pres = 32'sh7fffffff;
      end else if (psum < -33'sh080000000) begin
         pres = 32'sh80000000;
      end else begin
         pres = psum[31:0];
      end
   end

   assign behind_now = den_calc[17] || (den_calc == 18'sd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         world_x_ff   <= '0;
         world_y_ff   <= '0;
         world_z_ff   <= '0;
         eye_ff       <= EYE_RESET;
         rsp_valid_ff <= 1'b0;
         vi_ff        <= '0;
         step_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_WORLD_X: world_x_ff <= csr_data;
               REG_WORLD_Y: world_y_ff <= csr_data;
               REG_WORLD_Z: world_z_ff <= csr_data;
               REG_EYE:     eye_ff     <= csr_data[14:0];
               default:     eye_ff     <= eye_ff;
            endcase
         end
         if (mem_we) begin
            valid_ff[mem_wa] <= 1'b1;
         end
         case (state_ff)
            ST_IDLE: begin
               vi_ff   <= '0;
               step_ff <= '0;
            end
            ST_REDUCE: begin
               step_ff <= '0;
            end
            ST_CORDIC: begin
               step_ff <= step_ff + 4'd1;
               if (step_ff == 4'd15) begin
                  step_ff <= '0;
               end
            end
            ST_LATCH: begin
               step_ff <= '0;
            end
            ST_MUL: begin
               step_ff <= step_ff + 4'd1;
            end
            ST_WRITE: begin
               vi_ff <= vi_ff + CW'(1);
            end
            ST_EMIT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  vi_ff        <= vi_ff + CW'(1);
               end
            end
            ST_DIV_FIN: begin
               if (comp_ff == 2'd2) begin
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: begin
               step_ff <= step_ff;
            end
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            op_ff    <= req_op;
            plane_ff <= req_plane;
            ang_ff   <= 18'(req_angle);
         end
         ST_REDUCE: begin
            if (ang_ff[17]) begin
               ang_ff <= ang_ff + 18'sd36000;
            end else if (ang_ff >= 18'sd36000) begin
               ang_ff <= ang_ff - 18'sd36000;
            end else begin
               cz_ff   <= 25'(r_fold) <<< 8;
               flip_ff <= r_flip;
               cx_ff   <= 20'(CORDIC_X0);
               cy_ff   <= '0;
            end
         end
         ST_CORDIC: begin
            cx_ff <= cx_nx;
            cy_ff <= cy_nx;
            cz_ff <= cz_nx;
            if (step_ff == 4'd15) begin
               if (cx_nx > 20'sd16384) begin
                  cos_ff <= flip_ff ? -16'sd16384 : 16'sd16384;
               end else if (cx_nx < -20'sd16384) begin
                  cos_ff <= flip_ff ? 16'sd16384 : -16'sd16384;
               end else begin
                  cos_ff <= flip_ff ? -(cx_nx[15:0]) : cx_nx[15:0];
               end
               if (cy_nx > 20'sd16384) begin
                  sin_ff <= 16'sd16384;
               end else if (cy_nx < -20'sd16384) begin
                  sin_ff <= -16'sd16384;
               end else begin
                  sin_ff <= cy_nx[15:0];
               end
            end
         end
         ST_LATCH: begin
            vtx_ff  <= rvalid_ff ? rd_ff : reset_vertex(7'(vi_ff));
            comp_ff <= '0;
         end
         ST_MUL: begin
            acc_ff <= sum;
            if (step_ff[1:0] == 2'd1) begin
               tmp_ff <= rnd;
            end
            if (step_ff[1:0] == 2'd3) begin
               if (step_ff[2]) begin
                  vtx_ff.r <= tmp_ff;
                  vtx_ff.g <= rnd;
               end else begin
                  case (plane_ff)
                     3'd0:    begin vtx_ff.y <= tmp_ff; vtx_ff.z <= rnd; end
                     3'd1:    begin vtx_ff.x <= tmp_ff; vtx_ff.z <= rnd; end
                     3'd2:    begin vtx_ff.x <= tmp_ff; vtx_ff.y <= rnd; end
                     3'd3:    begin vtx_ff.z <= tmp_ff; vtx_ff.w <= rnd; end
                     3'd4:    begin vtx_ff.x <= tmp_ff; vtx_ff.w <= rnd; end
                     default: begin vtx_ff.y <= tmp_ff; vtx_ff.w <= rnd; end
                  endcase
               end
            end
         end
         ST_DIV_SETUP: begin
            behind_ff <= behind_now;
            den_ff    <= den_calc[16:0];
            neg_ff    <= pcoord[15];
            dvd_ff    <= DIV_W'({pabs, 13'd0}) + DIV_W'(den_calc[16:1]);
            rem_ff    <= '0;
            dcnt_ff   <= '0;
         end
         ST_DIV: begin
            dcnt_ff <= dcnt_ff + 5'd1;
            rem_ff  <= rem_ge ? 16'(rem_sh - den_ff) : rem_sh[15:0];
            dvd_ff  <= {dvd_ff[DIV_W-2:0], rem_ge};
         end
         ST_DIV_FIN: begin
            comp_ff <= comp_ff + 2'd1;
            case (comp_ff)
               2'd0:    px_ff <= pres;
               2'd1:    py_ff <= pres;
               default: pz_ff <= pres;
            endcase
         end
         default: begin
            acc_ff <= acc_ff;
         end
      endcase
   end

   // the behind flag is registered in the setup state for the outputs;
   // the early-out in the setup state uses the live comparison
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_index  = 4'(vi_ff);
   assign rsp_proj_x     = px_ff;
   assign rsp_proj_y     = py_ff;
   assign rsp_proj_z     = pz_ff;
   assign rsp_out_red    = vtx_ff.r;
   assign rsp_out_green  = vtx_ff.g;
   assign rsp_out_blue   = vtx_ff.b;
   assign rsp_behind_eye = behind_ff;
   assign rsp_last       = (vi_ff == EMIT_LAST);

endmodule

FILE: sim/four_d_rotate_project_engine_tb.sv
// testbench for the four-d rotate and project engine: scoreboard against a behavioural model
`timescale 1ns / 100ps

module four_d_rotate_project_engine_tb;
   import fdrp_pkg::*;

   typedef struct {
      logic [3:0]         idx;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic signed [15:0] r;
      logic signed [15:0] g;
      logic signed [15:0] b;
      logic               behind;
      logic               last;
   } vertex_out_type;

   class projection_scoreboard;
      longint vx[16], vy[16], vz[16], vw[16], vr[16], vg[16], vb[16];
      longint wx, wy, wz, eye;
      vertex_out_type pending[$];
      int errors;
      int seen;

      function void restore();
         for (int i = 0; i < 16; i++) begin
            vx[i] = i[0] ? 8192 : -8192;
            vy[i] = i[1] ? 8192 : -8192;
            vz[i] = i[2] ? 8192 : -8192;
            vw[i] = (i < 8) ? 0 : -8192;
            vr[i] = 8192;
            vg[i] = 8192;
            vb[i] = 8192;
         end
         wx = 0;
         wy = 0;
         wz = 0;
         eye = 16384;
         errors = 0;
         seen = 0;
      endfunction

      function void set_reg(reg_index_type ri, logic [31:0] d);
         case (ri)
            REG_WORLD_X: wx = longint'(signed'(d));
            REG_WORLD_Y: wy = longint'(signed'(d));
            REG_WORLD_Z: wz = longint'(signed'(d));
            default: eye = longint'(d[14:0]);
         endcase
      endfunction

      function longint shr(longint v, int s);
         return v >>> s;
      endfunction

      function longint clip16(longint v);
         return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
      endfunction

      function longint clip32(longint v);
         return v > 64'sd2147483647 ? 64'sd2147483647 :
                (v < -64'sd2147483648 ? -64'sd2147483648 : v);
      endfunction

      function void sin_cos(longint ang, output longint sv, output longint cv);
         longint r, x, y, z, dx, dy;
         bit flip;
         r = ang % FULL_TURN;
         flip = 0;
         x = CORDIC_X0;
         y = 0;
         if (r < 0) r += FULL_TURN;
         if (r > HALF_TURN) r -= FULL_TURN;
         if (r > QUARTER_TURN) begin
            r = HALF_TURN - r;
            flip = 1;
         end else if (r < -QUARTER_TURN) begin
            r = -HALF_TURN - r;
            flip = 1;
         end
         z = r * 256;
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = shr(y, i);
            dy = shr(x, i);
            if (z >= 0) begin
               x -= dx; y += dy; z -= longint'(atan_entry(4'(i)));
            end else begin
               x += dx; y -= dy; z += longint'(atan_entry(4'(i)));
            end
         end
         x = x > 16384 ? 16384 : (x < -16384 ? -16384 : x);
         y = y > 16384 ? 16384 : (y < -16384 ? -16384 : y);
         cv = flip ? -x : x;
         sv = y;
      endfunction

      function void spin(inout longint a, inout longint b, input longint s, input longint c);
         longint oa, ob;
         oa = a;
         ob = b;
         a = clip16(shr(c * oa - s * ob + 8192, 14));
         b = clip16(shr(s * oa + c * ob + 8192, 14));
      endfunction

      function longint persp(longint c, longint den, longint wo);
         longint num, mag, q;
         if (den <= 0)
            return c > 0 ? 64'sd2147483647 : (c < 0 ? -64'sd2147483648 : wo);
         num = c * 8192;
         mag = num < 0 ? -num : num;
         q = (mag + den / 2) / den;
         if (num < 0) q = -q;
         return clip32(q + wo);
      endfunction

      function void note_command(op_type op, logic [2:0] pl, logic signed [16:0] ang,
                                 logic [3:0] vi, logic signed [15:0] f[7]);
         longint s, c, den;
         vertex_out_type e;
         if (op == OP_LOAD) begin
            vx[vi] = f[0]; vy[vi] = f[1]; vz[vi] = f[2]; vw[vi] = f[3];
            vr[vi] = f[4]; vg[vi] = f[5]; vb[vi] = f[6];
         end else if (op == OP_ROTATE && pl <= 5) begin
            sin_cos(longint'(ang), s, c);
            for (int i = 0; i < 16; i++) begin
               case (pl)
                  0: spin(vy[i], vz[i], s, c);
                  1: spin(vx[i], vz[i], s, c);
                  2: spin(vx[i], vy[i], s, c);
                  3: spin(vz[i], vw[i], s, c);
                  4: spin(vx[i], vw[i], s, c);
                  default: spin(vy[i], vw[i], s, c);
               endcase
               spin(vr[i], vg[i], s, c);
            end
         end else if (op == OP_PROJECT) begin
            for (int i = 0; i < 16; i++) begin
               den = eye - vw[i];
               e.idx = 4'(i);
               e.px = 32'(persp(vx[i], den, wx));
               e.py = 32'(persp(vy[i], den, wy));
               e.pz = 32'(persp(vz[i], den, wz));
               e.r = 16'(vr[i]);
               e.g = 16'(vg[i]);
               e.b = 16'(vb[i]);
               e.behind = den <= 0;
               e.last = i == 15;
               pending.push_back(e);
            end
         end
      endfunction

      task check_vertex(vertex_out_type got);
         vertex_out_type e;
         seen++;
         if (pending.size() == 0) begin
            report_mismatch("unexpected beat", 0, 0);
            return;
         end
         e = pending.pop_front();
         if (got.idx !== e.idx) report_mismatch("index", got.idx, e.idx);
         if (got.px !== e.px) report_mismatch("proj_x", got.px, e.px);
         if (got.py !== e.py) report_mismatch("proj_y", got.py, e.py);
         if (got.pz !== e.pz) report_mismatch("proj_z", got.pz, e.pz);
         if (got.r !== e.r) report_mismatch("red", got.r, e.r);
         if (got.g !== e.g) report_mismatch("green", got.g, e.g);
         if (got.b !== e.b) report_mismatch("blue", got.b, e.b);
         if (got.behind !== e.behind) report_mismatch("behind_eye", got.behind, e.behind);
         if (got.last !== e.last) report_mismatch("last", got.last, e.last);
      endtask

      task report_mismatch(string what, longint got, longint want);
         errors++;
         if (errors <= 40) $display("mismatch %s: got %0d want %0d", what, got, want);
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_stall;
   op_type req_op = OP_LOAD;
   logic [2:0] req_plane = 0;
   logic signed [16:0] req_angle = 0;
   logic [3:0] req_vertex_index = 0;
   logic signed [15:0] req_pos_x = 0, req_pos_y = 0, req_pos_z = 0, req_pos_w = 0;
   logic signed [15:0] req_in_red = 0, req_in_green = 0, req_in_blue = 0;
   logic rsp_valid, rsp_stall = 0;
   logic [3:0] rsp_out_index;
   logic signed [31:0] rsp_proj_x, rsp_proj_y, rsp_proj_z;
   logic signed [15:0] rsp_out_red, rsp_out_green, rsp_out_blue;
   logic rsp_behind_eye, rsp_last;
   logic csr_valid = 0, csr_ready;
   reg_index_type csr_index = REG_WORLD_X;
   logic [31:0] csr_data = 0;

   projection_scoreboard board;
   bit quiet_phase = 0;
   bit hold_off = 0;
   int counts[4];

   four_d_rotate_project_engine i_dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   task automatic write_reg(reg_index_type ri, logic [31:0] d);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= ri;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      board.set_reg(ri, d);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic send(op_type op, logic [2:0] pl, logic signed [16:0] ang,
                       logic [3:0] vi, logic signed [15:0] f[7]);
      @(negedge clock);
      while (!quiet_phase && $urandom_range(99) < 22) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_op <= op;
      req_plane <= pl;
      req_angle <= ang;
      req_vertex_index <= vi;
      req_pos_x <= f[0]; req_pos_y <= f[1]; req_pos_z <= f[2]; req_pos_w <= f[3];
      req_in_red <= f[4]; req_in_green <= f[5]; req_in_blue <= f[6];
      do @(posedge clock); while (req_stall);
      board.note_command(op, pl, ang, vi, f);
      counts[op]++;
   endtask

   task automatic finish_send();
      @(negedge clock);
      req_valid <= 0;
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick16();
      case ($urandom_range(5))
         0: return 16'sh7fff;
         1: return -16'sh8000;
         2: return 16'($urandom);
         default: return 16'($signed($urandom_range(16384)) - 8192);
      endcase
   endfunction

   task automatic random_command();
      logic signed [15:0] f[7];
      int k;
      for (int i = 0; i < 7; i++) f[i] = pick16();
      k = $urandom_range(99);
      if (k < 55)
         send(OP_LOAD, 3'($urandom), 17'($urandom), 4'($urandom), f);
      else if (k < 80)
         send(OP_ROTATE, 3'($urandom), 17'($signed($urandom_range(72000)) - 36000),
              4'($urandom), f);
      else if (k < 97)
         send(OP_PROJECT, 3'($urandom), 17'($urandom), 4'($urandom), f);
      else
         send(OP_NONE, 3'($urandom), 17'($urandom), 4'($urandom), f);
   endtask

   always @(negedge clock) begin
      if (hold_off) rsp_stall <= 1;
      else if (quiet_phase) rsp_stall <= 0;
      else rsp_stall <= $urandom_range(99) < 22;
   end

   always @(posedge clock) begin
      vertex_out_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.idx = rsp_out_index;
         got.px = rsp_proj_x;
         got.py = rsp_proj_y;
         got.pz = rsp_proj_z;
         got.r = rsp_out_red;
         got.g = rsp_out_green;
         got.b = rsp_out_blue;
         got.behind = rsp_behind_eye;
         got.last = rsp_last;
         board.check_vertex(got);
      end
   end

   initial begin
      #10000000;
      $display("four_d_rotate_project_engine_tb failed");
      $finish;
   end

   initial begin
      logic signed [15:0] f[7];
      logic signed [16:0] angs[6];
      board = new();
      board.restore();
      angs = '{0, 36000, -36000, 9000, -18000, 13500};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: reset cube, extremes, every plane, behind the eye
      f = '{0, 0, 0, 0, 0, 0, 0};
      send(OP_PROJECT, 0, 0, 0, f);
      f = '{16'sh7fff, -16'sh8000, 0, 16'sh7fff, 16'sh7fff, -16'sh8000, 16'sh7fff};
      send(OP_LOAD, 0, 0, 15, f);
      f = '{-16'sh8000, 16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000, 16'sh7fff, -16'sh8000};
      send(OP_LOAD, 0, 0, 3, f);
      f = '{100, -100, 0, 16384, 1, 2, 3};
      send(OP_LOAD, 0, 0, 5, f);
      for (int p = 0; p < 8; p++) send(OP_ROTATE, 3'(p), angs[p % 6], 0, f);
      send(OP_ROTATE, 2, 17'sh0ffff, 0, f);
      send(OP_ROTATE, 2, -17'sh10000, 0, f);
      send(OP_NONE, 0, 0, 0, f);
      send(OP_PROJECT, 0, 0, 0, f);
      finish_send();
      drain();

      write_reg(REG_WORLD_X, 32'h7fffffff);
      write_reg(REG_WORLD_Y, 32'h80000000);
      write_reg(REG_WORLD_Z, 32'h00012345);
      write_reg(REG_EYE, 32'h00000001);
      send(OP_PROJECT, 0, 0, 0, f);
      finish_send();
      drain();
      write_reg(REG_EYE, 32'h00007fff);

      // random phases with differing settings
      for (int ph = 0; ph < 6; ph++) begin
         quiet_phase = ph == 2;
         if (ph == 4) fork
            begin
               hold_off = 1;
               repeat (3000) @(posedge clock);
               hold_off = 0;
            end
         join_none
         for (int n = 0; n < 80; n++) random_command();
         f = '{0, 0, 0, 0, 0, 0, 0};
         send(OP_PROJECT, 0, 0, 0, f);
         finish_send();
         drain();
         write_reg(REG_WORLD_X, $urandom);
         write_reg(REG_WORLD_Y, ph[0] ? 32'h80000000 : $urandom_range(65535));
         write_reg(REG_WORLD_Z, $urandom);
         write_reg(REG_EYE, ph == 3 ? 32'd1 : 32'($urandom_range(32767, 1)));
      end

      $display("covered %0d loads, %0d rotates, %0d projects, %0d unused ops",
               counts[0], counts[1], counts[2], counts[3]);
      $display("checked %0d projected vertices across several world and eye settings",
               board.seen);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("four_d_rotate_project_engine_tb passed");
      else
         $display("four_d_rotate_project_engine_tb failed");
      $finish;
   end

endmodule
